// File: rtl/mcwt_pkg.sv
// Shared constants for the multi-client watchdog table.
// Command and result codes, register map and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package mcwt_pkg;

   localparam int DEF_ENTRIES   = 16;
   localparam int DEF_TIME_BITS = 32;
   localparam int MAX_REPORTS   = 16;
   localparam int REP_W         = $clog2(MAX_REPORTS + 1);

   localparam int CMD_W   = 2;
   localparam int ID_W    = 16;
   localparam int LIMIT_W = 31;
   localparam int KIND_W  = 3;
   localparam int PER_W   = 24;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_KICK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

   localparam logic [KIND_W-1:0] K_REGISTERED = 3'd0;
   localparam logic [KIND_W-1:0] K_KICKED     = 3'd1;
   localparam logic [KIND_W-1:0] K_ALREADY    = 3'd2;
   localparam logic [KIND_W-1:0] K_NOT_REG    = 3'd3;
   localparam logic [KIND_W-1:0] K_FULL       = 3'd4;
   localparam logic [KIND_W-1:0] K_EXPIRED    = 3'd5;

   localparam logic [ADDR_W-1:0] ADDR_CHECK_PERIOD = 3'd0;
   localparam logic [PER_W-1:0]  CHECK_PERIOD_RESET = 24'd1000;

endpackage

// File: rtl/multi_client_watchdog_table.sv
// Top level of the multi-client watchdog table: command decode, table walk,
// expiry scan, result register and APB-style configuration register.
// Depends on mcwt_pkg.
`timescale 1ns / 1ps

// Usage
//   req_*  : one item per command (register, kick, tick); valid/ready.
//   rsp_*  : result items (kind, reported_id, last); valid/ready.
//   psel.. : APB-style port holding check_period at byte address 0.
// Register and kick items walk the entry memory one entry at a time (memory
// read in S_LRD, then compare in S_LEV), and stop early when the id is found.
// A tick without a scan is finished in the idle state.
// A scanning tick walks the whole memory and gives one expired result per
// expired entry, up to 16, the final one marked last.
// A new item is accepted whenever the walk is idle, even while a result is
// still held in the output register.
// Reset empties the table (valid and expired bits are flip-flops), clears
// time and period count and sets check_period to 1000. No clearing pass.
// When the receiver stalls, the walk holds at the next result to be given.
module multi_client_watchdog_table #(
   parameter int ENTRIES   = mcwt_pkg::DEF_ENTRIES,
   parameter int TIME_BITS = mcwt_pkg::DEF_TIME_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mcwt_pkg::CMD_W-1:0]     req_cmd,
   input  logic [mcwt_pkg::ID_W-1:0]      req_client_id,
   input  logic [mcwt_pkg::LIMIT_W-1:0]   req_time_limit,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mcwt_pkg::KIND_W-1:0]    rsp_kind,
   output logic [mcwt_pkg::ID_W-1:0]      rsp_reported_id,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mcwt_pkg::ADDR_W-1:0]    paddr,
   input  logic [mcwt_pkg::DATA_W-1:0]    pwdata,
   output logic [mcwt_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MEM_W = mcwt_pkg::ID_W + mcwt_pkg::LIMIT_W + TIME_BITS;
   localparam int CMP_W = (TIME_BITS > mcwt_pkg::LIMIT_W) ? TIME_BITS : mcwt_pkg::LIMIT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LRD  = 7'b0000010,
      S_LEV  = 7'b0000100,
      S_RESP = 7'b0001000,
      S_SRD  = 7'b0010000,
      S_SEV  = 7'b0100000,
      S_SFIN = 7'b1000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [TIME_BITS-1:0]            time_now_ff, time_now_in;
   logic [mcwt_pkg::PER_W-1:0]      period_ff, period_in;
   logic [mcwt_pkg::PER_W-1:0]      check_period_ff, check_period_in;
   logic [ENTRIES-1:0]              valid_ff, valid_in;
   logic [ENTRIES-1:0]              expired_ff, expired_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [mcwt_pkg::REP_W-1:0]      rep_ff, rep_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [mcwt_pkg::ID_W-1:0]       pend_id_ff, pend_id_in;
   logic [mcwt_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [mcwt_pkg::ID_W-1:0]       id_ff, id_in;
   logic [mcwt_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [mcwt_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mcwt_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [mcwt_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [MEM_W-1:0]                mem [ENTRIES];
   logic [MEM_W-1:0]                mem_q;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_wa;
   logic [MEM_W-1:0]                mem_wd;

   logic [mcwt_pkg::ID_W-1:0]       mem_id;
   logic [mcwt_pkg::LIMIT_W-1:0]    mem_limit;
   logic [TIME_BITS-1:0]            mem_last;
   logic [TIME_BITS-1:0]            elapsed;
   logic                            over_limit;
   logic                            out_free;
   logic                            hit;
   logic                            any_free;
   logic [IDX_W-1:0]                free_slot;
   logic                            scan_due;
   logic                            ent_exp;
   logic                            report;
   logic                            csr_wr;

   assign mem_last   = mem_q[TIME_BITS-1:0];
   assign mem_limit  = mem_q[TIME_BITS +: mcwt_pkg::LIMIT_W];
   assign mem_id     = mem_q[TIME_BITS + mcwt_pkg::LIMIT_W +: mcwt_pkg::ID_W];
   assign elapsed    = time_now_ff - mem_last;
   assign over_limit = CMP_W'(elapsed) > CMP_W'(mem_limit);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign hit        = valid_ff[idx_ff] && (mem_id == id_ff);
   assign any_free   = ~&valid_ff;
   assign scan_due   = ({1'b0, period_ff} + 25'd1) >= {1'b0, check_period_ff};
   assign ent_exp    = valid_ff[idx_ff] && (expired_ff[idx_ff] || over_limit);
   assign report     = ent_exp && (rep_ff < mcwt_pkg::REP_W'(mcwt_pkg::MAX_REPORTS));

   always_comb begin
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IDX_W'(i);
         end
      end
   end

   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == mcwt_pkg::ADDR_CHECK_PERIOD) ?
                   {{(mcwt_pkg::DATA_W - mcwt_pkg::PER_W){1'b0}}, check_period_ff} : '0;

   always_comb begin
      check_period_in = check_period_ff;
      if (csr_wr && (paddr == mcwt_pkg::ADDR_CHECK_PERIOD)) begin
         check_period_in = pwdata[mcwt_pkg::PER_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      time_now_in   = time_now_ff;
      period_in     = period_ff;
      valid_in      = valid_ff;
      expired_in    = expired_ff;
      idx_in        = idx_ff;
      rep_in        = rep_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      limit_in      = limit_ff;
      kind_in       = kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_wa        = idx_ff;
      mem_wd        = {id_ff, limit_ff, time_now_ff};
      req_ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               id_in    = req_client_id;
               limit_in = req_time_limit;
               unique case (req_cmd)
                  mcwt_pkg::CMD_REGISTER, mcwt_pkg::CMD_KICK: begin
                     idx_in   = '0;
                     state_in = S_LRD;
                  end
                  mcwt_pkg::CMD_TICK: begin
                     time_now_in = time_now_ff + TIME_BITS'(1);
                     if (scan_due) begin
                        period_in     = '0;
                        idx_in        = '0;
                        rep_in        = '0;
                        pend_valid_in = 1'b0;
                        state_in      = S_SRD;
                     end else begin
                        period_in = period_ff + 24'd1;
                     end
                  end
                  mcwt_pkg::CMD_UNUSED: begin
                  end
               endcase
            end
         end
         S_LRD: begin
            state_in = S_LEV;
         end
         S_LEV: begin
            if (hit) begin
               if (cmd_ff == mcwt_pkg::CMD_KICK) begin
                  mem_we             = 1'b1;
                  mem_wd             = {mem_id, mem_limit, time_now_ff};
                  expired_in[idx_ff] = 1'b0;
                  kind_in            = mcwt_pkg::K_KICKED;
               end else begin
                  kind_in = mcwt_pkg::K_ALREADY;
               end
               state_in = S_RESP;
            end else if (idx_ff == IDX_LAST) begin
               if (cmd_ff == mcwt_pkg::CMD_KICK) begin
                  kind_in = mcwt_pkg::K_NOT_REG;
               end else if (any_free) begin
                  mem_we                = 1'b1;
                  mem_wa                = free_slot;
                  valid_in[free_slot]   = 1'b1;
                  expired_in[free_slot] = 1'b0;
                  kind_in               = mcwt_pkg::K_REGISTERED;
               end else begin
                  kind_in = mcwt_pkg::K_FULL;
               end
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_LRD;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_id_in    = id_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SRD: begin
            state_in = S_SEV;
         end
         S_SEV: begin
            if (!(report && pend_valid_ff && !out_free)) begin
               if (valid_ff[idx_ff] && over_limit) begin
                  expired_in[idx_ff] = 1'b1;
               end
               if (report) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = mcwt_pkg::K_EXPIRED;
                     rsp_id_in    = pend_id_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = mem_id;
                  rep_in        = rep_ff + mcwt_pkg::REP_W'(1);
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = S_SFIN;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_SRD;
               end
            end
         end
         S_SFIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = mcwt_pkg::K_EXPIRED;
               rsp_id_in     = pend_id_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         time_now_ff     <= '0;
         period_ff       <= '0;
         check_period_ff <= mcwt_pkg::CHECK_PERIOD_RESET;
         valid_ff        <= '0;
         expired_ff      <= '0;
         idx_ff          <= '0;
         rep_ff          <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         time_now_ff     <= time_now_in;
         period_ff       <= period_in;
         check_period_ff <= check_period_in;
         valid_ff        <= valid_in;
         expired_ff      <= expired_in;
         idx_ff          <= idx_in;
         rep_ff          <= rep_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff  <= pend_id_in;
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      limit_ff    <= limit_in;
      kind_ff     <= kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_reported_id = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == mcwt_pkg::CMD_TICK))
      |=> (time_now_ff == $past(time_now_ff) + TIME_BITS'(1)))
      else $error("time counter did not advance on a tick item");

   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_ff <= mcwt_pkg::REP_W'(mcwt_pkg::MAX_REPORTS))
      else $error("scan reported more entries than allowed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != mcwt_pkg::K_EXPIRED)) |-> rsp_last_ff)
      else $error("non-expiry result without last flag");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending expiry left over after scan");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SRD) || (state_ff == S_SEV) || (state_ff == S_SFIN)) |-> !mem_we)
      else $error("entry memory written during scan");

endmodule
